/* rtl/cim_pkg.sv */
package cim_pkg;

    localparam int FIELD_W = 32;
    localparam int VAL_W   = 48;
    localparam int NUM_W   = FIELD_W + 2;
    localparam int QUO_W   = FIELD_W + 1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam int HORNER_STEPS = 3;
    localparam int L_HORNER     = 4 * HORNER_STEPS;
    localparam int L_SQRT       = 2 + FIELD_W;
    localparam int L_DIV        = 2 + FIELD_W;

    typedef struct packed {
        logic signed [FIELD_W-1:0] coef_3;
        logic signed [FIELD_W-1:0] coef_2;
        logic signed [FIELD_W-1:0] coef_1;
        logic signed [FIELD_W-1:0] coef_0;
    } t_coefs;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    sat;
    } t_eval;

endpackage

/* rtl/cim_in_if.sv */
interface cim_in_if;
    import cim_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] coef_0;
    logic signed [FIELD_W-1:0] coef_1;
    logic signed [FIELD_W-1:0] coef_2;
    logic signed [FIELD_W-1:0] coef_3;
    logic signed [FIELD_W-1:0] interval_low;
    logic signed [FIELD_W-1:0] interval_high;

    modport source (output valid, coef_0, coef_1, coef_2, coef_3, interval_low, interval_high,
                    input ready);
    modport sink (input valid, coef_0, coef_1, coef_2, coef_3, interval_low, interval_high,
                  output ready);
endinterface

/* rtl/cim_out_if.sv */
interface cim_out_if;
    import cim_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] best_t;
    logic signed [VAL_W-1:0]   min_value;
    logic                      value_saturated;

    modport source (output valid, best_t, min_value, value_saturated, input ready);
    modport sink (input valid, best_t, min_value, value_saturated, output ready);
endinterface

/* rtl/cim_delay.sv */
module cim_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];
endmodule

/* rtl/cim_horner.sv */
module cim_horner #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  cim_pkg::t_coefs                     i_coefs,
    input  logic signed [cim_pkg::FIELD_W-1:0]  i_t,
    output cim_pkg::t_eval                      o_eval
);
    import cim_pkg::*;

    localparam int PL_W    = 2 * FIELD_W;
    localparam int SH_UP   = FIELD_W - FRAC_BITS;
    localparam int BIG_SH  = VAL_W - 1 - FIELD_W + FRAC_BITS;
    localparam logic [PL_W-1:0] M_NEG = PL_W'(1) << (VAL_W - 1);
    localparam logic [PL_W-1:0] M_POS = M_NEG - PL_W'(1);

    typedef struct packed {
        t_coefs                    c;
        logic signed [FIELD_W-1:0] t;
    } t_ctx;

    function automatic logic signed [FIELD_W-1:0] pick_coef(t_coefs c, int step);
        case (step)
            0:       return c.coef_2;
            1:       return c.coef_1;
            default: return c.coef_0;
        endcase
    endfunction

    t_ctx                    b_x   [HORNER_STEPS+1];
    logic signed [VAL_W-1:0] b_acc [HORNER_STEPS+1];
    logic                    b_sat [HORNER_STEPS+1];

    assign b_x[0]   = '{c: i_coefs, t: i_t};
    assign b_acc[0] = VAL_W'(i_coefs.coef_3);
    assign b_sat[0] = 1'b0;

    // each step: magnitudes, partial products, scale and clip, add coefficient
    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
        t_ctx                    r_xa, r_xb, r_xc, r_xd;
        logic [VAL_W-1:0]        r_ua;
        logic [FIELD_W-1:0]      r_ut;
        logic                    r_nega, r_negb;
        logic                    r_sa, r_sb, r_sc, r_sd;
        logic [VAL_W-1:0]        r_ph;
        logic [PL_W-1:0]         r_pl;
        logic signed [VAL_W-1:0] r_mv, r_acc;
        logic [VAL_W-1:0]        n_ua;
        logic [FIELD_W-1:0]      n_ut;
        logic [PL_W-1:0]         w_m;
        logic                    w_big;
        logic signed [VAL_W-1:0] n_mv;
        logic                    n_sc;
        logic signed [VAL_W:0]   w_sum;
        logic signed [VAL_W-1:0] n_acc;
        logic                    n_sd;

        always_comb begin
            n_ua = b_acc[k][VAL_W-1] ? VAL_W'(-b_acc[k]) : VAL_W'(b_acc[k]);
            n_ut = b_x[k].t[FIELD_W-1] ? FIELD_W'(-b_x[k].t) : FIELD_W'(b_x[k].t);
        end

        always_comb begin
            w_big = |(r_ph >> BIG_SH);
            w_m   = (PL_W'(r_ph) << SH_UP) + (r_pl >> FRAC_BITS);
            n_sc  = r_sb;
            if (w_big) begin
                n_mv = r_negb ? VAL_MIN : VAL_MAX;
                n_sc = 1'b1;
            end else if (r_negb) begin
                if (w_m > M_NEG) begin
                    n_mv = VAL_MIN;
                    n_sc = 1'b1;
                end else begin
                    n_mv = VAL_W'(-w_m);
                end
            end else if (w_m > M_POS) begin
                n_mv = VAL_MAX;
                n_sc = 1'b1;
            end else begin
                n_mv = VAL_W'(w_m);
            end
        end

        always_comb begin
            w_sum = (VAL_W+1)'(pick_coef(r_xc.c, k)) + (VAL_W+1)'(r_mv);
            n_sd  = r_sc;
            if (w_sum[VAL_W] != w_sum[VAL_W-1]) begin
                n_acc = w_sum[VAL_W] ? VAL_MIN : VAL_MAX;
                n_sd  = 1'b1;
            end else begin
                n_acc = w_sum[VAL_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xa   <= b_x[k];
                r_ua   <= n_ua;
                r_ut   <= n_ut;
                r_nega <= b_acc[k][VAL_W-1] ^ b_x[k].t[FIELD_W-1];
                r_sa   <= b_sat[k];

                r_xb   <= r_xa;
                r_ph   <= r_ua[VAL_W-1:FIELD_W] * r_ut;
                r_pl   <= r_ua[FIELD_W-1:0] * r_ut;
                r_negb <= r_nega;
                r_sb   <= r_sa;

                r_xc   <= r_xb;
                r_mv   <= n_mv;
                r_sc   <= n_sc;

                r_xd   <= r_xc;
                r_acc  <= n_acc;
                r_sd   <= n_sd;
            end
        end

        assign b_x[k+1]   = r_xd;
        assign b_acc[k+1] = r_acc;
        assign b_sat[k+1] = r_sd;
    end

    assign o_eval.value = b_acc[HORNER_STEPS];
    assign o_eval.sat   = b_sat[HORNER_STEPS];
endmodule

/* rtl/cim_sqrt.sv */
module cim_sqrt (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [cim_pkg::FIELD_W-1:0] i_coef_1,
    input  logic signed [cim_pkg::FIELD_W-1:0] i_coef_2,
    input  logic signed [cim_pkg::FIELD_W-1:0] i_coef_3,
    output logic        [cim_pkg::FIELD_W-1:0] o_root,
    output logic                               o_ok
);
    import cim_pkg::*;

    localparam int SQ_W  = 2 * FIELD_W;
    localparam int STEPS = FIELD_W;

    logic signed [SQ_W-1:0] r_p, r_q;
    logic signed [SQ_W+2:0] w_q3, w_diff;
    logic [SQ_W-1:0]        r_x0;
    logic                   r_ok0;

    logic [SQ_W-1:0] b_x  [STEPS+1];
    logic [SQ_W-1:0] b_r  [STEPS+1];
    logic            b_ok [STEPS+1];

    // disc = c2^2 - 3*c1*c3, negative means no stationary points
    always_comb begin
        w_q3   = ((SQ_W+3)'(r_q) <<< 1) + (SQ_W+3)'(r_q);
        w_diff = (SQ_W+3)'(r_p) - w_q3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= i_coef_2 * i_coef_2;
            r_q   <= i_coef_1 * i_coef_3;
            r_x0  <= w_diff[SQ_W-1:0];
            r_ok0 <= !w_diff[SQ_W+2];
        end
    end

    assign b_x[0]  = r_x0;
    assign b_r[0]  = '0;
    assign b_ok[0] = r_ok0;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*j);
        logic [SQ_W-1:0] r_x, r_r;
        logic            r_ok;
        logic [SQ_W-1:0] w_t;

        assign w_t = b_r[j] + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ok <= b_ok[j];
                if (b_x[j] >= w_t) begin
                    r_x <= b_x[j] - w_t;
                    r_r <= (b_r[j] >> 1) + BIT;
                end else begin
                    r_x <= b_x[j];
                    r_r <= b_r[j] >> 1;
                end
            end
        end

        assign b_x[j+1]  = r_x;
        assign b_r[j+1]  = r_r;
        assign b_ok[j+1] = r_ok;
    end

    assign o_root = b_r[STEPS][FIELD_W-1:0];
    assign o_ok   = b_ok[STEPS];
endmodule

/* rtl/cim_div.sv */
module cim_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [cim_pkg::NUM_W-1:0] i_num,
    input  logic signed [cim_pkg::NUM_W-1:0] i_den,
    output logic signed [cim_pkg::QUO_W-1:0] o_quot,
    output logic                             o_ovf
);
    import cim_pkg::*;

    localparam int DW = NUM_W - 1;
    localparam int AW = DW + FRAC_BITS;
    localparam int CW = (AW > DW + FIELD_W) ? AW : DW + FIELD_W;

    logic [DW-1:0] w_nmag, w_dmag;
    logic [AW-1:0] w_a;
    logic [AW-1:0] r_a0;
    logic [DW-1:0] r_d0;
    logic          r_neg0, r_ov0;

    logic [AW-1:0]      b_rem [FIELD_W+1];
    logic [DW-1:0]      b_d   [FIELD_W+1];
    logic [FIELD_W-1:0] b_q   [FIELD_W+1];
    logic               b_neg [FIELD_W+1];
    logic               b_ov  [FIELD_W+1];

    logic signed [QUO_W-1:0] r_quot;
    logic                    r_ovf;

    always_comb begin
        w_nmag = i_num[NUM_W-1] ? DW'(-i_num) : DW'(i_num);
        w_dmag = i_den[NUM_W-1] ? DW'(-i_den) : DW'(i_den);
        w_a    = AW'(w_nmag) << FRAC_BITS;
    end

    // quotient of 2^32 or more cannot land in a 32 bit interval
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0   <= w_a;
            r_d0   <= w_dmag;
            r_neg0 <= i_num[NUM_W-1] ^ i_den[NUM_W-1];
            r_ov0  <= CW'(w_a) >= (CW'(w_dmag) << FIELD_W);
        end
    end

    assign b_rem[0] = r_a0;
    assign b_d[0]   = r_d0;
    assign b_q[0]   = '0;
    assign b_neg[0] = r_neg0;
    assign b_ov[0]  = r_ov0;

    for (genvar i = 0; i < FIELD_W; i++) begin : g_step
        logic [AW-1:0]      r_rem;
        logic [DW-1:0]      r_d;
        logic [FIELD_W-1:0] r_q;
        logic               r_neg, r_ov;
        logic [CW-1:0]      w_ds;
        logic               w_ge;

        assign w_ds = CW'(b_d[i]) << (FIELD_W - 1 - i);
        assign w_ge = CW'(b_rem[i]) >= w_ds;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? AW'(CW'(b_rem[i]) - w_ds) : b_rem[i];
                r_q   <= {b_q[i][FIELD_W-2:0], w_ge};
                r_d   <= b_d[i];
                r_neg <= b_neg[i];
                r_ov  <= b_ov[i];
            end
        end

        assign b_rem[i+1] = r_rem;
        assign b_d[i+1]   = r_d;
        assign b_q[i+1]   = r_q;
        assign b_neg[i+1] = r_neg;
        assign b_ov[i+1]  = r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= b_neg[FIELD_W] ? -QUO_W'(b_q[FIELD_W]) : QUO_W'(b_q[FIELD_W]);
            r_ovf  <= b_ov[FIELD_W];
        end
    end

    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;
endmodule

/* rtl/cubic_interval_minimum.sv */
// Finds the lowest value of a fixed-point cubic on [interval_low, interval_high]: both ends
// are evaluated by Horner and, when the stationary points exist and both fall inside the
// interval, they are evaluated too and may replace the end. Fully pipelined: one request is
// taken every clock unless the pipeline holds. The path is a chain of a 34-stage square
// root (discriminant plus one root bit per stage), a 34-stage restoring divider
// (one quotient bit per stage) and a 12-stage Horner evaluator (three multiply-add steps
// of four stages each), with a few glue stages. A two-entry output register with skid
// keeps taking requests while one result waits; the pipeline only holds when both
// entries are full.
module cubic_interval_minimum #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cim_in_if.sink    i_req,
    cim_out_if.source o_res
);
    import cim_pkg::*;

    localparam int T_END  = L_HORNER;
    localparam int T_BEST = T_END + 1;
    localparam int T_SQ   = L_SQRT;
    localparam int T_DIV  = T_SQ + 1 + L_DIV;
    localparam int T_RNG  = T_DIV + 1;
    localparam int T_ROOT = T_RNG + L_HORNER;
    localparam int T_FIN  = T_ROOT + 1;

    typedef struct packed {
        t_coefs                    coefs;
        logic signed [FIELD_W-1:0] lo;
        logic signed [FIELD_W-1:0] hi;
    } t_item;

    typedef struct packed {
        t_item it;
        logic  ok;
        logic  c3nz;
    } t_side;

    typedef struct packed {
        logic signed [FIELD_W-1:0] t;
        t_eval                     e;
    } t_best;

    typedef struct packed {
        logic                      both_in;
        logic signed [FIELD_W-1:0] r1;
        logic signed [FIELD_W-1:0] r2;
    } t_roots;

    logic        w_en, w_acc, w_take, w_out_free;
    logic [T_FIN:1] r_vld;
    t_coefs      w_coefs;
    t_item       w_item, w_d1;
    t_side       w_s1, w_d2;
    logic [2*FIELD_W-1:0] w_ends;
    logic signed [FIELD_W-1:0] w_lo_e, w_hi_e;
    t_eval       w_el, w_eh, w_e1, w_e2;
    t_best       r_best, w_best_d, n_fin, r_fin;
    logic [FIELD_W-1:0] w_root;
    logic        w_ok;
    logic signed [NUM_W-1:0] w_c2x, w_c3x, w_sx;
    logic signed [NUM_W-1:0] r_n1, r_n2, r_den;
    logic signed [QUO_W-1:0] w_q1, w_q2, w_lo_x, w_hi_x;
    logic        w_ov1, w_ov2;
    t_roots      n_roots, r_roots, w_roots_d;
    t_coefs      r_rc;
    t_best       r_out, r_sk;
    logic        r_ov, r_skv;

    assign w_en  = !r_skv;
    assign w_acc = i_req.valid && w_en;
    assign i_req.ready = w_en;

    assign w_coefs = '{coef_3: i_req.coef_3, coef_2: i_req.coef_2,
                       coef_1: i_req.coef_1, coef_0: i_req.coef_0};
    assign w_item  = '{coefs: w_coefs, lo: i_req.interval_low, hi: i_req.interval_high};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[T_FIN-1:1], w_acc};
        end
    end

    // ends of the interval
    cim_horner #(.FRAC_BITS(FRAC_BITS)) u_eval_lo (
        .i_clk(i_clk), .i_en(w_en), .i_coefs(w_coefs), .i_t(i_req.interval_low), .o_eval(w_el)
    );
    cim_horner #(.FRAC_BITS(FRAC_BITS)) u_eval_hi (
        .i_clk(i_clk), .i_en(w_en), .i_coefs(w_coefs), .i_t(i_req.interval_high), .o_eval(w_eh)
    );
    cim_delay #(.WIDTH(2*FIELD_W), .DEPTH(T_END)) u_dly_ends (
        .i_clk(i_clk), .i_en(w_en), .i_d({i_req.interval_low, i_req.interval_high}), .o_q(w_ends)
    );
    assign w_lo_e = w_ends[2*FIELD_W-1:FIELD_W];
    assign w_hi_e = w_ends[FIELD_W-1:0];

    // equal values pick the upper end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_el.value < w_eh.value) begin
                r_best <= '{t: w_lo_e, e: w_el};
            end else begin
                r_best <= '{t: w_hi_e, e: w_eh};
            end
        end
    end
    cim_delay #(.WIDTH($bits(t_best)), .DEPTH(T_ROOT - T_BEST)) u_dly_best (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_best), .o_q(w_best_d)
    );

    // stationary points
    cim_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(w_en), .i_coef_1(i_req.coef_1), .i_coef_2(i_req.coef_2),
        .i_coef_3(i_req.coef_3), .o_root(w_root), .o_ok(w_ok)
    );
    cim_delay #(.WIDTH($bits(t_item)), .DEPTH(T_SQ)) u_dly_item (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_item), .o_q(w_d1)
    );

    always_comb begin
        w_c2x = NUM_W'(w_d1.coefs.coef_2);
        w_c3x = NUM_W'(w_d1.coefs.coef_3);
        w_sx  = NUM_W'(w_root);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1  <= -w_c2x - w_sx;
            r_n2  <= -w_c2x + w_sx;
            r_den <= (w_c3x <<< 1) + w_c3x;
        end
    end

    assign w_s1 = '{it: w_d1, ok: w_ok, c3nz: (w_d1.coefs.coef_3 != '0)};
    cim_delay #(.WIDTH($bits(t_side)), .DEPTH(T_DIV - T_SQ)) u_dly_side (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_s1), .o_q(w_d2)
    );

    cim_div #(.FRAC_BITS(FRAC_BITS)) u_div_1 (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_n1), .i_den(r_den), .o_quot(w_q1), .o_ovf(w_ov1)
    );
    cim_div #(.FRAC_BITS(FRAC_BITS)) u_div_2 (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_n2), .i_den(r_den), .o_quot(w_q2), .o_ovf(w_ov2)
    );

    // both roots must sit inside the interval, otherwise neither is tried
    always_comb begin
        w_lo_x = QUO_W'(w_d2.it.lo);
        w_hi_x = QUO_W'(w_d2.it.hi);
        n_roots.both_in = w_d2.ok && w_d2.c3nz && !w_ov1 && !w_ov2
                          && (w_q1 >= w_lo_x) && (w_q1 <= w_hi_x)
                          && (w_q2 >= w_lo_x) && (w_q2 <= w_hi_x);
        n_roots.r1 = w_q1[FIELD_W-1:0];
        n_roots.r2 = w_q2[FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roots <= n_roots;
            r_rc    <= w_d2.it.coefs;
        end
    end

    cim_horner #(.FRAC_BITS(FRAC_BITS)) u_eval_r1 (
        .i_clk(i_clk), .i_en(w_en), .i_coefs(r_rc), .i_t(r_roots.r1), .o_eval(w_e1)
    );
    cim_horner #(.FRAC_BITS(FRAC_BITS)) u_eval_r2 (
        .i_clk(i_clk), .i_en(w_en), .i_coefs(r_rc), .i_t(r_roots.r2), .o_eval(w_e2)
    );
    cim_delay #(.WIDTH($bits(t_roots)), .DEPTH(L_HORNER)) u_dly_roots (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_roots), .o_q(w_roots_d)
    );

    // minus root first, strict improvement only
    always_comb begin
        n_fin = w_best_d;
        if (w_roots_d.both_in) begin
            if (w_e1.value < n_fin.e.value) begin
                n_fin = '{t: w_roots_d.r1, e: w_e1};
            end
            if (w_e2.value < n_fin.e.value) begin
                n_fin = '{t: w_roots_d.r2, e: w_e2};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    // output register plus skid entry
    assign w_take     = w_en && r_vld[T_FIN];
    assign w_out_free = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (w_out_free) begin
            if (r_skv) begin
                r_out <= r_sk;
                r_ov  <= 1'b1;
                r_skv <= 1'b0;
            end else begin
                r_ov <= w_take;
                if (w_take) begin
                    r_out <= r_fin;
                end
            end
        end else if (w_take) begin
            r_sk  <= r_fin;
            r_skv <= 1'b1;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.best_t          = r_out.t;
    assign o_res.min_value       = r_out.e.value;
    assign o_res.value_saturated = r_out.e.sat;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> r_ov)
        else $error("skid entry full while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv && o_res.ready |=> !r_skv && r_ov)
        else $error("skid entry did not move to output");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv && r_vld[T_FIN] |=> r_vld[T_FIN])
        else $error("finished request lost during stall");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_res.ready && !r_skv && r_vld[T_FIN] |=> r_skv)
        else $error("finished request not caught by skid entry");
endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cim_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int N_RANDOM  = 900;
    localparam int QUIET_TAIL = 100;
    localparam longint POS_LIM = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint NEG_LIM = -64'sh0000_7FFF_FFFF_FFFF - 1;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct {
        logic signed [FIELD_W-1:0] c0, c1, c2, c3, lo, hi;
        bit                        typed;
        logic signed [FIELD_W-1:0] t_typed;
        logic signed [VAL_W-1:0]   v_typed;
        bit                        s_typed;
    } t_query;

    typedef struct {
        logic signed [FIELD_W-1:0] t;
        logic signed [VAL_W-1:0]   v;
        bit                        s;
    } t_minimum;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors = 0;
    bit   quiet = 1'b0;

    t_query   directed_rows[$];
    t_minimum minima_due[$];

    cim_in_if  req_if();
    cim_out_if res_if();

    cubic_interval_minimum #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clip_value(longint v, inout bit sat);
        if (v > POS_LIM) begin
            sat = 1'b1;
            return POS_LIM;
        end
        if (v < NEG_LIM) begin
            sat = 1'b1;
            return NEG_LIM;
        end
        return v;
    endfunction

    // trunc toward zero of a*t / 2^FRAC_BITS, clipped; split into two partial products
    function automatic longint scaled_product(longint a, longint t, inout bit sat);
        bit neg;
        longint unsigned ua, ut, ph, pl, m;
        neg = (a < 0) != (t < 0);
        ua = (a < 0) ? (64'd0 - a) : a;
        ut = (t < 0) ? (64'd0 - t) : t;
        ph = (ua >> 32) * ut;
        pl = (ua & 64'hFFFF_FFFF) * ut;
        if ((ph >> (15 + FRAC_BITS)) != 0) begin
            sat = 1'b1;
            return neg ? NEG_LIM : POS_LIM;
        end
        m = (ph << (32 - FRAC_BITS)) + (pl >> FRAC_BITS);
        if (neg) begin
            if (m > (64'd1 << 47)) begin
                sat = 1'b1;
                return NEG_LIM;
            end
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF_FFFF) begin
            sat = 1'b1;
            return POS_LIM;
        end
        return longint'(m);
    endfunction

    function automatic longint horner(longint c[4], longint t, output bit sat);
        longint acc;
        sat = 1'b0;
        acc = c[3];
        for (int k = 2; k >= 0; k--)
            acc = clip_value(c[k] + scaled_product(acc, t, sat), sat);
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_minimum predict_minimum(t_query q);
        t_minimum res;
        longint c[4];
        longint lo, hi, vl, vh, best_t, best_v, v, s, den, r1, r2, cq;
        longint unsigned p, d;
        bit sl, sh, sr, best_s, ok;
        c[0] = q.c0; c[1] = q.c1; c[2] = q.c2; c[3] = q.c3;
        lo = q.lo; hi = q.hi;
        vl = horner(c, lo, sl);
        vh = horner(c, hi, sh);
        if (vl < vh) begin
            best_t = lo; best_v = vl; best_s = sl;
        end else begin
            best_t = hi; best_v = vh; best_s = sh;
        end
        if (c[3] != 0) begin
            p = c[2] * c[2];
            cq = c[1] * c[3];
            ok = 1'b1;
            d = 0;
            // discriminant wraps at 64 bits like the unsigned sum it is defined by
            if (cq <= 0)
                d = p + 64'd3 * (64'd0 - cq);
            else if (p >= 64'd3 * longint'(cq))
                d = p - 64'd3 * cq;
            else
                ok = 1'b0;
            if (ok) begin
                s = longint'(int_sqrt(d));
                den = 3 * c[3];
                r1 = ((-c[2] - s) * (64'sd1 <<< FRAC_BITS)) / den;
                r2 = ((-c[2] + s) * (64'sd1 <<< FRAC_BITS)) / den;
                if (r1 >= lo && r1 <= hi && r2 >= lo && r2 <= hi) begin
                    v = horner(c, r1, sr);
                    if (v < best_v) begin
                        best_t = r1; best_v = v; best_s = sr;
                    end
                    v = horner(c, r2, sr);
                    if (v < best_v) begin
                        best_t = r2; best_v = v; best_s = sr;
                    end
                end
            end
        end
        res.t = best_t[31:0];
        res.v = best_v[47:0];
        res.s = best_s;
        return res;
    endfunction

    task automatic add_row(logic signed [31:0] c0, c1, c2, c3, lo, hi, bit typed = 0,
                           logic signed [31:0] et = 0, logic signed [47:0] ev = 0,
                           bit es = 0);
        t_query q;
        q.c0 = c0; q.c1 = c1; q.c2 = c2; q.c3 = c3; q.lo = lo; q.hi = hi;
        q.typed = typed; q.t_typed = et; q.v_typed = ev; q.s_typed = es;
        directed_rows.push_back(q);
    endtask

    function automatic logic signed [31:0] small_fix(int span);
        return $signed($urandom_range(2 * span * 65536)) - span * 65536;
    endfunction

    function automatic t_query random_query();
        t_query q;
        int kind;
        kind = $urandom_range(9);
        q.typed = 0;
        q.c0 = small_fix(16); q.c1 = small_fix(16); q.c2 = small_fix(16);
        q.c3 = small_fix(4);
        if (kind < 2) begin
            // raw noise across all bits
            q.c0 = $urandom; q.c1 = $urandom; q.c2 = $urandom; q.c3 = $urandom;
            q.lo = $urandom; q.hi = $urandom;
        end else if (kind == 2) begin
            q.c3 = 0;
            q.lo = small_fix(64); q.hi = small_fix(64);
        end else begin
            // interval around the origin, wide so both stationary points often fall inside, narrow for kind 9
            if (q.c3 == 0)
                q.c3 = ONE;
            q.lo = -$signed($urandom_range(32 * 65536));
            q.hi = $signed($urandom_range(32 * 65536));
            if (kind == 9) begin
                q.lo = -$signed($urandom_range(2 * 65536));
                q.hi = $signed($urandom_range(2 * 65536));
            end
        end
        return q;
    endfunction

    task automatic send_query(t_query q);
        t_minimum m;
        req_if.coef_0 = q.c0; req_if.coef_1 = q.c1; req_if.coef_2 = q.c2;
        req_if.coef_3 = q.c3; req_if.interval_low = q.lo; req_if.interval_high = q.hi;
        req_if.valid = 1'b1;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        if (q.typed) begin
            m.t = q.t_typed; m.v = q.v_typed; m.s = q.s_typed;
        end else begin
            m = predict_minimum(q);
        end
        minima_due.push_back(m);
        @(negedge i_clk);
        if (!quiet && $urandom_range(3) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    // receiver stalls
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(2) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_minimum m;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (minima_due.size() == 0) begin
                $display("%0t: unexpected result t=%h v=%h s=%b", $realtime,
                         res_if.best_t, res_if.min_value, res_if.value_saturated);
                errors++;
            end else begin
                m = minima_due.pop_front();
                if (res_if.best_t !== m.t) begin
                    $display("%0t: best_t expected %h actual %h", $realtime, m.t,
                             res_if.best_t);
                    errors++;
                end
                if (res_if.min_value !== m.v) begin
                    $display("%0t: min_value expected %h actual %h", $realtime, m.v,
                             res_if.min_value);
                    errors++;
                end
                if (res_if.value_saturated !== m.s) begin
                    $display("%0t: value_saturated expected %b actual %b", $realtime, m.s,
                             res_if.value_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.coef_0 = 0; req_if.coef_1 = 0; req_if.coef_2 = 0; req_if.coef_3 = 0;
        req_if.interval_low = 0; req_if.interval_high = 0;

        add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // equal end values pick the upper end
        add_row(32'sh7FFF_FFFF, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1,
                32'sh7FFF_FFFF, 48'sh0000_7FFF_FFFF, 0);
        add_row(0, ONE, 0, 0, -2 * ONE, 3 * ONE, 1, -2 * ONE, -48'sd131072, 0);
        // reversed interval: ends only
        add_row(0, ONE, 0, 0, 3 * ONE, -2 * ONE, 1, -2 * ONE, -48'sd131072, 0);
        add_row(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1,
                32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1);
        add_row(0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_row(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        add_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh7FFF_FFFF);
        add_row(-1, -1, -1, -1, -1, -1);
        add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh7FFF_FFFF);
        add_row(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF);
        // t^3 - 3t: both stationary points inside; an equal stationary value keeps the end, a lower one replaces it
        add_row(0, -3 * ONE, 0, ONE, -2 * ONE, 3 * ONE);
        add_row(0, -3 * ONE, 0, ONE, -3 * ONE / 2, 3 * ONE);
        // only one stationary point inside
        add_row(0, -3 * ONE, 0, ONE, 0, 3 * ONE);
        // negative discriminant
        add_row(0, 3 * ONE, 0, ONE, -2 * ONE, 2 * ONE);
        add_row(ONE, -3 * ONE, 0, -ONE, -2 * ONE, 2 * ONE);
        // quadratic with no cubic term, then two cubics
        add_row(0, -4 * ONE, ONE, 0, -5 * ONE, 5 * ONE);
        add_row(5, -7 * ONE, 2 * ONE, ONE, -10 * ONE, 10 * ONE);
        add_row(0, 1, 0, 1, -ONE, ONE);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_query(directed_rows[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                req_if.valid = 1'b0;
                wait (minima_due.size() == 0);
                @(negedge i_clk);
            end
            if (n == N_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            send_query(random_query());
        end
        req_if.valid = 1'b0;
        wait (minima_due.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end
endmodule

/* filelist.f */
rtl/cim_pkg.sv
rtl/cim_in_if.sv
rtl/cim_out_if.sv
rtl/cim_delay.sv
rtl/cim_horner.sv
rtl/cim_sqrt.sv
rtl/cim_div.sv
rtl/cubic_interval_minimum.sv
tb/tb.sv
